// ===== rtl/core/avt_pkg.sv =====
// shared types, constants and trig table builder for the affine vertex transform
package avt_pkg;

  localparam int FACTOR_WIDTH = 12;
  localparam int MODE_WIDTH   = 4;
  localparam int ANGLE_WIDTH  = 9;
  localparam int OUT_WIDTH    = 16;
  localparam int REG_DATA_W   = 32;
  localparam int REG_ADDR_W   = 4;
  localparam int REG_IDX_W    = 2;

  localparam int COORD_WIDTH_DEF    = 12;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int QUEUE_DEPTH        = 4;

  localparam int HALF_TURN = 180;
  localparam int FULL_TURN = 360;

  localparam longint Q30_ONE = 64'sd1 <<< 30;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE     = 2'd0,
    REG_FACTOR_X = 2'd1,
    REG_FACTOR_Y = 2'd2,
    REG_ROTATE   = 2'd3
  } reg_idx_e;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_SCALE     = 4'd0,
    MODE_ROTATE    = 4'd1,
    MODE_TRANSLATE = 4'd2,
    MODE_REFL_X    = 4'd3,
    MODE_REFL_Y    = 4'd4,
    MODE_REFL_DIAG = 4'd5,
    MODE_REFL_ORIG = 4'd6,
    MODE_SHEAR_X   = 4'd7,
    MODE_SHEAR_Y   = 4'd8
  } mode_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // sine or cosine of deg * 3.14 / 180, taylor on a/8 plus three angle doublings,
  // rounded half away from zero to frac fraction bits
  function automatic longint trig_fixed(int deg, int frac, bit want_cos);
    longint a;
    longint a2;
    longint s;
    longint c;
    longint term;
    longint ns;
    longint nc;
    longint v;
    longint half;
    longint r;
    int     sh;
    int     i;
    a  = (longint'(deg) * 64'sd314 * (64'sd1 <<< 27) + 64'sd9000) / 64'sd18000;
    a2 = a * a / Q30_ONE;
    s  = a;
    c  = Q30_ONE;
    // sine terms, divisors k*(k+1) for k = 2, 4, .. 12
    term = a;
    term = term * a2 / Q30_ONE / 64'sd6;
    s = s - term;
    term = term * a2 / Q30_ONE / 64'sd20;
    s = s + term;
    term = term * a2 / Q30_ONE / 64'sd42;
    s = s - term;
    term = term * a2 / Q30_ONE / 64'sd72;
    s = s + term;
    term = term * a2 / Q30_ONE / 64'sd110;
    s = s - term;
    term = term * a2 / Q30_ONE / 64'sd156;
    s = s + term;
    // cosine terms, divisors k*(k+1) for k = 1, 3, .. 11
    term = Q30_ONE;
    term = term * a2 / Q30_ONE / 64'sd2;
    c = c - term;
    term = term * a2 / Q30_ONE / 64'sd12;
    c = c + term;
    term = term * a2 / Q30_ONE / 64'sd30;
    c = c - term;
    term = term * a2 / Q30_ONE / 64'sd56;
    c = c + term;
    term = term * a2 / Q30_ONE / 64'sd90;
    c = c - term;
    term = term * a2 / Q30_ONE / 64'sd132;
    c = c + term;
    for (i = 0; i < 3; i++) begin
      ns = 2 * s * c / Q30_ONE;
      nc = (c * c - s * s) / Q30_ONE;
      s = ns;
      c = nc;
    end
    v    = want_cos ? c : s;
    sh   = 30 - frac;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) r = (v + half) >>> sh;
    else        r = -((-v + half) >>> sh);
    return r;
  endfunction

endpackage

// ===== rtl/core/avt_front.sv =====
// front end: accepts vertices, tracks the polygon pivot, pushes words to the queue
module avt_front #(
  parameter int COORD_WIDTH = avt_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [COORD_WIDTH-1:0]     in_x_i,
  input  logic [COORD_WIDTH-1:0]     in_y_i,
  input  logic                       in_last_i,
  input  avt_pkg::q_status_t         q_status_i,
  output logic                       q_push_o,
  // {last, pivot_y, pivot_x, y, x}
  output logic [4*COORD_WIDTH:0]     q_data_o
);

  logic                   awaiting_q, awaiting_d;
  logic [COORD_WIDTH-1:0] pivot_x_q, pivot_x_d;
  logic [COORD_WIDTH-1:0] pivot_y_q, pivot_y_d;
  logic                   accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  always_comb begin
    awaiting_d = awaiting_q;
    pivot_x_d  = pivot_x_q;
    pivot_y_d  = pivot_y_q;
    if (accept) begin
      awaiting_d = in_last_i;
      if (awaiting_q) begin
        pivot_x_d = in_x_i;
        pivot_y_d = in_y_i;
      end
    end
  end

  assign q_data_o = {in_last_i, pivot_y_d, pivot_x_d, in_y_i, in_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      pivot_x_q  <= '0;
      pivot_y_q  <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      pivot_x_q  <= pivot_x_d;
      pivot_y_q  <= pivot_y_d;
    end
  end

endmodule

// ===== rtl/core/avt_queue.sv =====
// short fifo between front end and transform pipeline
module avt_queue #(
  parameter int DATA_WIDTH = 4 * avt_pkg::COORD_WIDTH_DEF + 1,
  parameter int DEPTH      = avt_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  input  logic                  pop_i,
  output logic [DATA_WIDTH-1:0] pop_data_o,
  output avt_pkg::q_status_t    status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/core/avt_back.sv =====
// transform pipeline: trig lookup, product stage, sum/round/saturate output stage
module avt_back #(
  parameter int COORD_WIDTH    = avt_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = avt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [avt_pkg::MODE_WIDTH-1:0]        mode_i,
  input  logic [avt_pkg::FACTOR_WIDTH-1:0]      factor_x_i,
  input  logic [avt_pkg::FACTOR_WIDTH-1:0]      factor_y_i,
  input  logic [avt_pkg::ANGLE_WIDTH-1:0]       rotate_degrees_i,
  input  avt_pkg::q_status_t                    q_status_i,
  input  logic [4*COORD_WIDTH:0]                q_data_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [avt_pkg::OUT_WIDTH-1:0]         out_x_o,
  output logic [avt_pkg::OUT_WIDTH-1:0]         out_y_o,
  output logic                                  out_last_o
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = TRIG_FRAC_BITS;
  localparam int TW    = F + 2;
  localparam int BW    = (TW > avt_pkg::FACTOR_WIDTH) ? TW : avt_pkg::FACTOR_WIDTH;
  localparam int AW    = W + 1;
  localparam int PW    = AW + BW;
  localparam int KW    = W + F + 1;
  localparam int SW    = PW + 2;
  localparam int IDX_W = $clog2(avt_pkg::HALF_TURN);
  localparam int OW    = avt_pkg::OUT_WIDTH;
  localparam int DW    = avt_pkg::ANGLE_WIDTH;

  // trig tables, split in two half turns
  logic signed [TW-1:0] sin_lo [avt_pkg::HALF_TURN];
  logic signed [TW-1:0] cos_lo [avt_pkg::HALF_TURN];
  logic signed [TW-1:0] sin_hi [avt_pkg::HALF_TURN];
  logic signed [TW-1:0] cos_hi [avt_pkg::HALF_TURN];

  for (genvar gi = 0; gi < avt_pkg::HALF_TURN; gi++) begin : g_trig
    localparam longint SinLo = avt_pkg::trig_fixed(gi, F, 1'b0);
    localparam longint CosLo = avt_pkg::trig_fixed(gi, F, 1'b1);
    localparam longint SinHi = avt_pkg::trig_fixed(gi + avt_pkg::HALF_TURN, F, 1'b0);
    localparam longint CosHi = avt_pkg::trig_fixed(gi + avt_pkg::HALF_TURN, F, 1'b1);
    assign sin_lo[gi] = TW'(SinLo);
    assign cos_lo[gi] = TW'(CosLo);
    assign sin_hi[gi] = TW'(SinHi);
    assign cos_hi[gi] = TW'(CosHi);
  end

  logic [DW-1:0]        deg_eff;
  logic                 deg_hi;
  logic [IDX_W-1:0]     deg_idx;
  logic signed [TW-1:0] sin_d, sin_q;
  logic signed [TW-1:0] cos_d, cos_q;

  always_comb begin
    deg_eff = (rotate_degrees_i >= DW'(avt_pkg::FULL_TURN))
            ? rotate_degrees_i - DW'(avt_pkg::FULL_TURN) : rotate_degrees_i;
    deg_hi  = (deg_eff >= DW'(avt_pkg::HALF_TURN));
    deg_idx = deg_hi ? IDX_W'(deg_eff - DW'(avt_pkg::HALF_TURN)) : deg_eff[IDX_W-1:0];
    sin_d   = deg_hi ? sin_hi[deg_idx] : sin_lo[deg_idx];
    cos_d   = deg_hi ? cos_hi[deg_idx] : cos_lo[deg_idx];
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  // handshake chain
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_en, out_en;

  assign out_en  = !out_valid_q || out_ready_i;
  assign s1_en   = !s1_valid_q || out_en;
  assign q_pop_o = !q_status_i.empty && s1_en;

  always_comb begin
    s1_valid_d  = s1_en ? q_pop_o : s1_valid_q;
    out_valid_d = out_en ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operand selection
  logic signed [W-1:0]  vx, vy, px, py;
  logic                 vlast;
  logic signed [AW-1:0] ex, ey, dx, dy;
  logic signed [BW-1:0] fx, fy, one, neg_one, sin_b, cos_b;
  logic signed [AW-1:0] ax0, ax1, ay0, ay1;
  logic signed [BW-1:0] bx0, bx1, by0, by1;
  logic signed [KW-1:0] kx, ky, half;
  logic                 rot;

  always_comb begin
    vx    = q_data_i[W-1:0];
    vy    = q_data_i[2*W-1:W];
    px    = q_data_i[3*W-1:2*W];
    py    = q_data_i[4*W-1:3*W];
    vlast = q_data_i[4*W];
    ex    = AW'(vx);
    ey    = AW'(vy);
    dx    = ex - AW'(px);
    dy    = ey - AW'(py);
    fx      = BW'($signed(factor_x_i));
    fy      = BW'($signed(factor_y_i));
    one     = BW'(1);
    neg_one = -BW'(1);
    sin_b   = BW'(sin_q);
    cos_b   = BW'(cos_q);
    half    = KW'(1) <<< (F - 1);
    ax0 = ex;  bx0 = one;  ax1 = '0;  bx1 = '0;  kx = '0;
    ay0 = ey;  by0 = one;  ay1 = '0;  by1 = '0;  ky = '0;
    rot = 1'b0;
    unique case (avt_pkg::mode_e'(mode_i))
      avt_pkg::MODE_SCALE: begin
        bx0 = fx;
        by0 = fy;
      end
      avt_pkg::MODE_ROTATE: begin
        rot = 1'b1;
        ax0 = dx;  bx0 = cos_b;  ax1 = dy;  bx1 = -sin_b;
        ay0 = dx;  by0 = sin_b;  ay1 = dy;  by1 = cos_b;
        kx  = (KW'(px) <<< F) + half;
        ky  = (KW'(py) <<< F) + half;
      end
      avt_pkg::MODE_TRANSLATE: begin
        kx = KW'(fx);
        ky = KW'(fy);
      end
      avt_pkg::MODE_REFL_X: begin
        by0 = neg_one;
      end
      avt_pkg::MODE_REFL_Y: begin
        bx0 = neg_one;
      end
      avt_pkg::MODE_REFL_DIAG: begin
        ax0 = ey;
        ay0 = ex;
      end
      avt_pkg::MODE_REFL_ORIG: begin
        bx0 = neg_one;
        by0 = neg_one;
      end
      avt_pkg::MODE_SHEAR_X: begin
        ax1 = ey;
        bx1 = fx;
      end
      avt_pkg::MODE_SHEAR_Y: begin
        ay1 = ex;
        by1 = fx;
      end
      default: begin
      end
    endcase
  end

  // product stage
  logic signed [PW-1:0] px0_q, px1_q, py0_q, py1_q;
  logic signed [KW-1:0] kx_q, ky_q;
  logic                 rot_q, last_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      px0_q  <= ax0 * bx0;
      px1_q  <= ax1 * bx1;
      py0_q  <= ay0 * by0;
      py1_q  <= ay1 * by1;
      kx_q   <= kx;
      ky_q   <= ky;
      rot_q  <= rot;
      last_q <= vlast;
    end
  end

  // sum, floor shift and saturation
  logic signed [SW-1:0] sum_x, sum_y, res_x, res_y;
  logic signed [OW-1:0] sat_x, sat_y;

  always_comb begin
    sum_x = SW'(px0_q) + SW'(px1_q) + SW'(kx_q);
    sum_y = SW'(py0_q) + SW'(py1_q) + SW'(ky_q);
    res_x = rot_q ? (sum_x >>> F) : sum_x;
    res_y = rot_q ? (sum_y >>> F) : sum_y;
    if (res_x > SW'(32767))       sat_x = OW'(32767);
    else if (res_x < -SW'(32768)) sat_x = OW'(-32768);
    else                          sat_x = res_x[OW-1:0];
    if (res_y > SW'(32767))       sat_y = OW'(32767);
    else if (res_y < -SW'(32768)) sat_y = OW'(-32768);
    else                          sat_y = res_y[OW-1:0];
  end

  logic [OW-1:0] out_x_q, out_y_q;
  logic          out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_x_q    <= sat_x;
      out_y_q    <= sat_y;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/core/affine_vertex_transform_2d.sv =====
// top level: register port, front end, queue and transform pipeline
// an input word is queued, then registered in the product stage and the output stage
// throughput: one vertex per cycle while the output is not stalled
// a 4-entry queue lets the input side keep taking words while the output stalls
// the angle table is read into a register in the cycle after rotate_degrees is written
// reset: async active low; registers to defaults, queue and pipeline empty, new polygon
module affine_vertex_transform_2d #(
  parameter int COORD_WIDTH    = avt_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = avt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_x, vertex_y, zero padding
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_x, out_y
  output logic [2*avt_pkg::OUT_WIDTH-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [avt_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [avt_pkg::REG_DATA_W-1:0]     pwdata,
  output logic [avt_pkg::REG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int W  = COORD_WIDTH;
  localparam int EW = 4 * W + 1;
  localparam int FW = avt_pkg::FACTOR_WIDTH;
  localparam int MW = avt_pkg::MODE_WIDTH;
  localparam int DW = avt_pkg::ANGLE_WIDTH;
  localparam int RW = avt_pkg::REG_DATA_W;

  logic [MW-1:0] mode_q, mode_d;
  logic [FW-1:0] factor_x_q, factor_x_d;
  logic [FW-1:0] factor_y_q, factor_y_d;
  logic [DW-1:0] rotate_q, rotate_d;
  logic          reg_wr;
  avt_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = avt_pkg::reg_idx_e'(paddr[avt_pkg::REG_ADDR_W-1:2]);

  always_comb begin
    mode_d     = mode_q;
    factor_x_d = factor_x_q;
    factor_y_d = factor_y_q;
    rotate_d   = rotate_q;
    if (reg_wr) begin
      unique case (reg_idx)
        avt_pkg::REG_MODE:     mode_d     = pwdata[MW-1:0];
        avt_pkg::REG_FACTOR_X: factor_x_d = pwdata[FW-1:0];
        avt_pkg::REG_FACTOR_Y: factor_y_d = pwdata[FW-1:0];
        avt_pkg::REG_ROTATE:   rotate_d   = pwdata[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      avt_pkg::REG_MODE:     prdata = RW'(mode_q);
      avt_pkg::REG_FACTOR_X: prdata = RW'(factor_x_q);
      avt_pkg::REG_FACTOR_Y: prdata = RW'(factor_y_q);
      avt_pkg::REG_ROTATE:   prdata = RW'(rotate_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      factor_x_q <= FW'(1);
      factor_y_q <= FW'(1);
      rotate_q   <= '0;
    end else begin
      mode_q     <= mode_d;
      factor_x_q <= factor_x_d;
      factor_y_q <= factor_y_d;
      rotate_q   <= rotate_d;
    end
  end

  avt_pkg::q_status_t  q_status;
  logic                q_push, q_pop;
  logic [EW-1:0]       q_wdata, q_rdata;
  logic [avt_pkg::OUT_WIDTH-1:0] out_x, out_y;

  avt_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_x_i     (s_axis_tdata[W-1:0]),
    .in_y_i     (s_axis_tdata[2*W-1:W]),
    .in_last_i  (s_axis_tlast),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  avt_queue #(
    .DATA_WIDTH (EW),
    .DEPTH      (avt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  avt_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .factor_x_i       (factor_x_q),
    .factor_y_i       (factor_y_q),
    .rotate_degrees_i (rotate_q),
    .q_status_i       (q_status),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_x_o          (out_x),
    .out_y_o          (out_y),
    .out_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {out_y, out_x};

endmodule
